>>> rtl/core/llt_pkg.sv
`default_nettype none

package llt_pkg;

    // command codes of an input item
    localparam logic [2:0] CMD_LISTEN     = 3'd0;
    localparam logic [2:0] CMD_TALK       = 3'd1;
    localparam logic [2:0] CMD_HOST_WRITE = 3'd2;
    localparam logic [2:0] CMD_HOST_READ  = 3'd3;
    localparam logic [2:0] CMD_RESTART    = 3'd4;

    // register indexes on the config port
    localparam logic [2:0] REG_BUFFER_LIMIT = 3'd0;
    localparam logic [2:0] REG_STOP_CHAR    = 3'd1;
    localparam logic [2:0] REG_LISTEN_STOP  = 3'd2;
    localparam logic [2:0] REG_RUN_AGAIN    = 3'd3;
    localparam logic [2:0] REG_TALK_END     = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    // sticky status bits
    localparam int ST_FULL  = 0;
    localparam int ST_OVER  = 1;
    localparam int ST_EMPTY = 2;
    localparam int ST_UNDER = 3;

    // spent condition bits (low three line up with listen stop modes)
    localparam int SP_END  = 0;
    localparam int SP_CRLF = 1;
    localparam int SP_CHAR = 2;
    localparam int SP_TALK = 3;

    localparam logic [8:0] LIMIT_RESET = 9'd256;
    localparam logic [7:0] STOP_RESET  = 8'd10;

    typedef struct packed {
        logic [8:0] buffer_limit;
        logic [7:0] stop_char;
        logic [2:0] listen_stop_modes;
        logic [1:0] run_again_modes;
        logic       talk_last_is_end;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/llt_ram.sv
`default_nettype none

module llt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/llt_cfg.sv
`default_nettype none

module llt_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output llt_pkg::cfg_t      cfg
);
    import llt_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BUFFER_LIMIT: cfg_next.buffer_limit      = pwdata[8:0];
                REG_STOP_CHAR:    cfg_next.stop_char         = pwdata[7:0];
                REG_LISTEN_STOP:  cfg_next.listen_stop_modes = pwdata[2:0];
                REG_RUN_AGAIN:    cfg_next.run_again_modes   = pwdata[1:0];
                REG_TALK_END:     cfg_next.talk_last_is_end  = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BUFFER_LIMIT: prdata = {23'd0, cfg_reg.buffer_limit};
            REG_STOP_CHAR:    prdata = {24'd0, cfg_reg.stop_char};
            REG_LISTEN_STOP:  prdata = {29'd0, cfg_reg.listen_stop_modes};
            REG_RUN_AGAIN:    prdata = {30'd0, cfg_reg.run_again_modes};
            REG_TALK_END:     prdata = {31'd0, cfg_reg.talk_last_is_end};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.buffer_limit      <= LIMIT_RESET;
            cfg_reg.stop_char         <= STOP_RESET;
            cfg_reg.listen_stop_modes <= 3'd0;
            cfg_reg.run_again_modes   <= 2'd0;
            cfg_reg.talk_last_is_end  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/llt_core.sv
`default_nettype none

module llt_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire llt_pkg::cfg_t cfg,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_cmd,
    input  wire logic [7:0]    s_frame_byte,
    input  wire logic          s_frame_end,
    input  wire logic [7:0]    s_host_index,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_out_end,
    output logic               m_out_last,
    output logic               m_out_none,
    output logic               m_halt_request,
    output logic               m_full_flag,
    output logic               m_overflow_flag,
    output logic               m_empty_flag,
    output logic               m_underflow_flag,
    output logic [8:0]         m_fill_count
);
    import llt_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = (PW > 9) ? PW : 9;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    // input stage
    logic       in_valid_reg;
    logic [2:0] cmd_reg;
    logic [7:0] fbyte_reg;
    logic       fend_reg;
    logic [7:0] hidx_reg;

    // block state
    logic [PW-1:0] pos_reg,    pos_next;
    logic [3:0]    sticky_reg, sticky_next;
    logic [3:0]    spent_reg,  spent_next;

    // result stage
    logic       out_valid_reg;
    logic       byte_sel_reg, byte_sel_next;
    logic       end_reg,      end_next;
    logic       last_reg,     last_next;
    logic       none_reg,     none_next;
    logic       halt_reg,     halt_next;
    logic [3:0] flags_reg;
    logic [8:0] fill_reg;

    logic          adv;
    logic [CW-1:0] lim, lim_cfg, pos_ext, pos_inc, pos_step, hidx_ext, pos_next_ext;
    logic [2:0]    armed;
    logic          trim, host_ok;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    // item moves from input stage into result stage
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    assign lim_cfg  = CW'(cfg.buffer_limit);
    assign lim      = (lim_cfg < DEPTH_C) ? lim_cfg : DEPTH_C;
    assign pos_ext  = CW'(pos_reg);
    assign pos_inc  = pos_ext + CW'(1);
    assign hidx_ext = CW'(hidx_reg);
    assign host_ok  = hidx_ext < DEPTH_C;
    assign armed    = cfg.listen_stop_modes & ~spent_reg[2:0];

    always_comb begin
        pos_step      = pos_ext;
        sticky_next   = sticky_reg;
        spent_next    = spent_reg;
        byte_sel_next = 1'b0;
        end_next      = 1'b0;
        last_next     = 1'b0;
        none_next     = 1'b0;
        halt_next     = 1'b0;
        trim          = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = pos_ext[AW-1:0];
        ram_raddr     = pos_ext[AW-1:0];
        unique case (cmd_reg)
            CMD_LISTEN: begin
                if (pos_ext < lim) begin
                    ram_we = adv;
                    if (armed[SP_END] && fend_reg) begin
                        halt_next           = 1'b1;
                        spent_next[SP_END]  = 1'b1;
                        sticky_next[ST_FULL] = 1'b1;
                    end
                    if (armed[SP_CRLF]) begin
                        if (fbyte_reg == CHAR_CR) begin
                            trim = 1'b1;
                        end else if (fbyte_reg == CHAR_LF) begin
                            trim                 = 1'b1;
                            halt_next            = 1'b1;
                            spent_next[SP_CRLF]  = 1'b1;
                            sticky_next[ST_FULL] = 1'b1;
                        end
                    end
                    if (armed[SP_CHAR] && fbyte_reg == cfg.stop_char) begin
                        trim                 = 1'b1;
                        halt_next            = 1'b1;
                        spent_next[SP_CHAR]  = 1'b1;
                        sticky_next[ST_FULL] = 1'b1;
                    end
                    // trimmed bytes leave the pointer where it was
                    pos_step = trim ? pos_ext : pos_inc;
                    if (pos_step == lim) begin
                        if (!cfg.run_again_modes[0]) begin
                            halt_next = 1'b1;
                        end
                        sticky_next[ST_FULL] = 1'b1;
                    end
                end else begin
                    halt_next            = 1'b1;
                    sticky_next[ST_OVER] = 1'b1;
                end
            end
            CMD_TALK: begin
                if (pos_ext < lim) begin
                    ram_re        = adv;
                    byte_sel_next = 1'b1;
                    pos_step      = pos_inc;
                    if (pos_inc == lim) begin
                        if (!cfg.run_again_modes[1]) begin
                            if (cfg.talk_last_is_end && !spent_reg[SP_TALK]) begin
                                spent_next[SP_TALK] = 1'b1;
                                end_next            = 1'b1;
                            end
                            last_next = 1'b1;
                        end
                        sticky_next[ST_EMPTY] = 1'b1;
                    end
                end else begin
                    none_next             = 1'b1;
                    sticky_next[ST_UNDER] = 1'b1;
                end
            end
            CMD_HOST_WRITE: begin
                ram_we    = adv && host_ok;
                ram_waddr = hidx_ext[AW-1:0];
            end
            CMD_HOST_READ: begin
                ram_re        = adv && host_ok;
                ram_raddr     = hidx_ext[AW-1:0];
                byte_sel_next = host_ok;
            end
            CMD_RESTART: begin
                pos_step    = '0;
                sticky_next = '0;
                spent_next  = '0;
            end
            default: begin
                pos_step = pos_ext;
            end
        endcase
    end

    assign pos_next     = pos_step[PW-1:0];
    assign pos_next_ext = CW'(pos_next);

    llt_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (fbyte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sticky_reg    <= '0;
            spent_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                sticky_reg    <= sticky_next;
                spent_reg     <= spent_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg   <= s_cmd;
            fbyte_reg <= s_frame_byte;
            fend_reg  <= s_frame_end;
            hidx_reg  <= s_host_index;
        end
        if (adv) begin
            byte_sel_reg <= byte_sel_next;
            end_reg      <= end_next;
            last_reg     <= last_next;
            none_reg     <= none_next;
            halt_reg     <= halt_next;
            flags_reg    <= sticky_next;
            fill_reg     <= pos_next_ext[8:0];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_byte       = byte_sel_reg ? ram_rdata : 8'd0;
    assign m_out_end        = end_reg;
    assign m_out_last       = last_reg;
    assign m_out_none       = none_reg;
    assign m_halt_request   = halt_reg;
    assign m_full_flag      = flags_reg[ST_FULL];
    assign m_overflow_flag  = flags_reg[ST_OVER];
    assign m_empty_flag     = flags_reg[ST_EMPTY];
    assign m_underflow_flag = flags_reg[ST_UNDER];
    assign m_fill_count     = fill_reg;

endmodule

`default_nettype wire

>>> rtl/core/loop_listen_talk_buffer.sv
// Byte buffer behind a serial loop port. Each transfer on the s_ channel carries one
// command (listen frame, talk request, host write, host read, restart) and produces
// exactly one transfer on the m_ channel, in order. Listen frames fill the buffer at
// the shared pointer and may end on the frame END bit, on CR/LF or on a chosen stop
// character (CR, LF and the stop character are dropped from the buffer); talk requests
// drain it from the same pointer. Each stop condition fires once until a restart.
// m_valid rises once the s_ transfer has passed one input register, then the
// pointer/status update and the buffer RAM access into the result register. A new
// command is taken every cycle; the only throughput limit is backpressure on m_ready,
// which propagates straight back to s_ready. The buffer RAM has no reset: reading a
// location that was never written (by talk or host read) returns garbage. Registers
// sit on a 32-bit APB port at byte offsets 0x00 buffer_limit, 0x04 stop_char,
// 0x08 listen_stop_modes, 0x0C run_again_modes, 0x10 talk_last_is_end; write them
// only while no command is in flight.
`default_nettype none

module loop_listen_talk_buffer #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // command channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_frame_end,
    input  wire logic [7:0]  s_host_index,

    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_out_end,
    output logic             m_out_last,
    output logic             m_out_none,
    output logic             m_halt_request,
    output logic             m_full_flag,
    output logic             m_overflow_flag,
    output logic             m_empty_flag,
    output logic             m_underflow_flag,
    output logic [8:0]       m_fill_count
);
    import llt_pkg::*;

    cfg_t cfg;

    // register file; pready is tied high, writes land on the access phase
    llt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pointer, status, stop logic and buffer RAM
    llt_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_frame_byte     (s_frame_byte),
        .s_frame_end      (s_frame_end),
        .s_host_index     (s_host_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_end        (m_out_end),
        .m_out_last       (m_out_last),
        .m_out_none       (m_out_none),
        .m_halt_request   (m_halt_request),
        .m_full_flag      (m_full_flag),
        .m_overflow_flag  (m_overflow_flag),
        .m_empty_flag     (m_empty_flag),
        .m_underflow_flag (m_underflow_flag),
        .m_fill_count     (m_fill_count)
    );

endmodule

`default_nettype wire
